// ----- hw/rtl/amax_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amax_pkg
// Shared widths, defaults and controller/datapath command and status types
// for the execution-time vector max merge block.
// ----------------------------------------------------------------------------
package amax_pkg;

  localparam int VALUE_W          = 48;
  localparam int OPERAND_W        = 3;
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int OPERANDS_DEF     = 8;

  typedef struct packed {
    logic load;        // input request accepted this cycle
    logic scan_clr;    // start a new head scan
    logic scan_rd;     // read head of operand at scan index
    logic emit_elem;   // emit best head as merged element
    logic emit_cap;    // emit best head as final floor
    logic emit_floor;  // emit current floor as final floor
  } amax_cmd_t;

  typedef struct packed {
    logic start;       // accepted request closes the final operand
    logic found;       // a head above the floor was found
    logic cap;         // element budget down to its last entry
    logic out_free;    // result register can take a new request
  } amax_status_t;

endpackage

// ----- hw/rtl/amax_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amax_ifs
// Valid/ready channel interfaces for input requests and merged results.
// ----------------------------------------------------------------------------
interface amax_in_if;
  logic                            valid;
  logic                            ready;
  logic [amax_pkg::OPERAND_W-1:0]  operand;
  logic [amax_pkg::VALUE_W-1:0]    value;
  logic                            closes_operand;
  logic                            last_operand;

  modport source(output valid, operand, value, closes_operand, last_operand, input ready);
  modport sink(input valid, operand, value, closes_operand, last_operand, output ready);
endinterface

interface amax_out_if;
  logic                          valid;
  logic                          ready;
  logic [amax_pkg::VALUE_W-1:0]  merged_value;
  logic                          is_floor;
  logic                          last;

  modport source(output valid, merged_value, is_floor, last, input ready);
  modport sink(input valid, merged_value, is_floor, last, output ready);
endinterface

// ----- hw/rtl/awcet_merge_max.sv -----
`timescale 1ns / 1ps
// Steps: each merged element needs one memory read per operand head, one compare
//   drain and one decide, which waits while the result register is busy.
// Throughput: loading at one request per cycle during the load phase; merge set
//   by the element memory scan of the operand heads, up to the floor.
// Reset: synchronous active-low rst_n clears counts, positions, floor and
//   control state at once; the element memory is not cleared.
// ----------------------------------------------------------------------------
// awcet_merge_max
// Loads execution-time vectors and merges them by greedy maximum, emitting
// merged elements and the final floor value.
// ----------------------------------------------------------------------------
module awcet_merge_max #(
  parameter int MAX_ELEMENTS = amax_pkg::MAX_ELEMENTS_DEF,
  parameter int OPERANDS     = amax_pkg::OPERANDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  amax_in_if.sink     in_if,
  amax_out_if.source  out_if
);

  localparam int OW = $clog2(OPERANDS);

  amax_pkg::amax_cmd_t    cmd;
  amax_pkg::amax_status_t status;
  logic [OW-1:0]          scan_idx;
  logic                   in_ready;

  assign in_if.ready = in_ready;

  amax_ctrl #(
    .OPERANDS (OPERANDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  amax_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .OPERANDS     (OPERANDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operand        (in_if.operand),
    .in_value          (in_if.value),
    .in_closes_operand (in_if.closes_operand),
    .in_last_operand   (in_if.last_operand),
    .cmd               (cmd),
    .scan_idx          (scan_idx),
    .status            (status),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_merged_value  (out_if.merged_value),
    .out_is_floor      (out_if.is_floor),
    .out_last          (out_if.last)
  );

`ifndef ASSERT_OFF
  a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_elem, cmd.emit_cap, cmd.emit_floor}))
    else $error("more than one emit command");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_elem || cmd.emit_cap || cmd.emit_floor) |-> status.out_free)
    else $error("emit while result register busy");

  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    status.start |=> !in_ready)
    else $error("input still open after merge start");

  a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !in_ready && !cmd.load)
    else $error("load during head scan");
`endif

endmodule

// ----- hw/rtl/amax_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amax_ctrl
// Controller: load phase, per-result head scan over all operands, and the
// decision to emit an element or the closing floor.
// ----------------------------------------------------------------------------
module amax_ctrl #(
  parameter int OPERANDS = amax_pkg::OPERANDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  amax_pkg::amax_status_t        status,
  output amax_pkg::amax_cmd_t           cmd,
  output logic [$clog2(OPERANDS)-1:0]   scan_idx
);

  localparam int OW = $clog2(OPERANDS);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [OW-1:0] idx_r;
  logic [OW-1:0] idx_nxt;
  logic          idx_last;

  assign idx_last = (idx_r == OW'(OPERANDS - 1));
  assign scan_idx = idx_r;
  assign in_ready = (state_r == ST_LOAD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = in_valid;
        if (status.start) begin
          cmd.scan_clr = 1'b1;
          idx_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + OW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.out_free) begin
          priority if (status.found && !status.cap) begin
            cmd.emit_elem = 1'b1;
            cmd.scan_clr  = 1'b1;
            idx_nxt       = '0;
            state_nxt     = ST_SCAN;
          end else if (status.found) begin
            cmd.emit_cap = 1'b1;
            state_nxt    = ST_LOAD;
          end else begin
            cmd.emit_floor = 1'b1;
            state_nxt      = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- hw/rtl/amax_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amax_dp
// Datapath: element memory, per-operand counts and read positions, floor,
// head compare stage, emitted count and the result register.
// ----------------------------------------------------------------------------
module amax_dp #(
  parameter int MAX_ELEMENTS = amax_pkg::MAX_ELEMENTS_DEF,
  parameter int OPERANDS     = amax_pkg::OPERANDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [amax_pkg::OPERAND_W-1:0]  in_operand,
  input  logic [amax_pkg::VALUE_W-1:0]    in_value,
  input  logic                            in_closes_operand,
  input  logic                            in_last_operand,
  input  amax_pkg::amax_cmd_t             cmd,
  input  logic [$clog2(OPERANDS)-1:0]     scan_idx,
  output amax_pkg::amax_status_t          status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [amax_pkg::VALUE_W-1:0]    out_merged_value,
  output logic                            out_is_floor,
  output logic                            out_last
);

  localparam int VW    = amax_pkg::VALUE_W;
  localparam int OW    = $clog2(OPERANDS);
  localparam int PW    = $clog2(MAX_ELEMENTS);
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int DEPTH = OPERANDS * (2 ** PW);

  logic [VW-1:0]    mem [DEPTH];
  logic [CW-1:0]    counts_r [OPERANDS];
  logic [CW-1:0]    pos_r [OPERANDS];
  logic [VW-1:0]    floor_r;
  logic             seen_r;
  logic [CW-1:0]    emitted_r;

  logic [VW-1:0]    rd_data_r;
  logic             pend_r;
  logic             head_ok_r;
  logic [OW-1:0]    head_src_r;
  logic             found_r;
  logic [VW-1:0]    best_r;
  logic [OW-1:0]    src_r;

  logic             out_valid_r;
  logic [VW-1:0]    out_value_r;
  logic             out_floor_r;

  logic             op_ok;
  logic [OW-1:0]    op_idx;
  logic [OW-1:0]    cnt_addr;
  logic [CW-1:0]    cnt_sel;
  logic [CW-1:0]    pos_sel;
  logic             elem_wr;
  logic             floor_wr;
  logic             hit;
  logic             clear_run;
  logic             emit_any;

  assign op_ok    = (32'(in_operand) < OPERANDS);
  assign op_idx   = OW'(in_operand);
  assign cnt_addr = cmd.load ? op_idx : scan_idx;
  assign cnt_sel  = counts_r[cnt_addr];
  assign pos_sel  = pos_r[scan_idx];
  assign elem_wr  = cmd.load && op_ok && !in_closes_operand && (cnt_sel < CW'(MAX_ELEMENTS));
  assign floor_wr = cmd.load && op_ok && in_closes_operand;

  assign hit = pend_r && head_ok_r && (rd_data_r > floor_r)
               && (!found_r || (rd_data_r > best_r));

  assign clear_run = cmd.emit_cap || cmd.emit_floor;
  assign emit_any  = cmd.emit_elem || clear_run;

  assign status.start    = floor_wr && in_last_operand;
  assign status.found    = found_r;
  assign status.cap      = (emitted_r == CW'(MAX_ELEMENTS - 1));
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_is_floor     = out_floor_r;
  assign out_last         = out_floor_r;

  // element memory
  always_ff @(posedge clk) begin
    if (elem_wr) begin
      mem[{op_idx, cnt_sel[PW-1:0]}] <= in_value;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= mem[{scan_idx, pos_sel[PW-1:0]}];
    end
  end

  // head scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      head_ok_r  <= (pos_sel < cnt_sel);
      head_src_r <= scan_idx;
    end
    if (hit) begin
      best_r <= rd_data_r;
      src_r  <= head_src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_rd;
      if (cmd.scan_clr) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  // run bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || clear_run) begin
      for (int i = 0; i < OPERANDS; i++) begin
        counts_r[i] <= '0;
        pos_r[i]    <= '0;
      end
      floor_r   <= '0;
      seen_r    <= 1'b0;
      emitted_r <= '0;
    end else begin
      if (elem_wr) begin
        counts_r[op_idx] <= cnt_sel + CW'(1);
      end
      if (floor_wr) begin
        if (!seen_r || (in_value > floor_r)) begin
          floor_r <= in_value;
        end
        seen_r <= 1'b1;
      end
      if (cmd.emit_elem) begin
        pos_r[src_r] <= pos_r[src_r] + CW'(1);
        emitted_r    <= emitted_r + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_any) begin
      out_value_r <= cmd.emit_floor ? floor_r : best_r;
      out_floor_r <= clear_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
